[sv/multi_channel_timer_bank_unit_macros.svh]
// assertion macros used by the timer bank back end (mctb_back)
`ifndef MULTI_CHANNEL_TIMER_BANK_UNIT_MACROS_SVH
`define MULTI_CHANNEL_TIMER_BANK_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define MCTB_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("mctb: invariant violated");

// consequent holds in the same cycle as the antecedent
`define MCTB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mctb: implication violated");

// consequent holds in the cycle after the antecedent
`define MCTB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mctb: next-cycle check violated");

`endif

[sv/mctb_pkg.sv]
package mctb_pkg;

   localparam int NumSlotsDef = 16;
   localparam int MaxResults  = 16;
   localparam int ResCntW     = 5;
   localparam int ResIdxW     = 4;
   localparam int UsPerMs     = 1000;
   localparam int TimeW       = 48;
   localparam int IvlW        = 32;
   localparam int ProdW       = 42;
   localparam int NtW         = 40;
   localparam int RemW        = 10;
   localparam int ExtW        = 9;
   localparam int DivCntW     = 6;
   localparam logic [TimeW-1:0] TimeMax = '1;

   // division by 1000 in 16-bit chunks: remainder and chunk make a 26-bit value,
   // whose quotient is (value * ceil(2^36 / 1000)) >> 36, exact below 2^26
   localparam int ChunkW     = 16;
   localparam int ValW       = 26;
   localparam int RecipW     = 53;
   localparam int RecipShift = 36;
   localparam logic [26:0] RecipM = 27'd68719477;
   localparam int DivSteps   = 6;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_RESET  = 2'd2,
      CMD_RUN    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_INACTIVE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [3:0]       slot_index;
      logic [IvlW-1:0]  interval_ms;
      logic             repeat_mode;
      logic [TimeW-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [3:0]            slot_out;
      logic [1:0]            status;
      logic                  fired;
      logic signed [NtW-1:0] next_timeout_ms;
      logic                  last_result;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      cmd_type          cmd;
      logic [3:0]       idx;
      logic [IvlW-1:0]  ivl;
      logic             rep;
      logic [TimeW-1:0] now;
   } job_type;

   typedef struct packed {
      logic [3:0] slot;
      status_type status;
      logic       fired;
   } res_type;

endpackage

[sv/mctb_front.sv]
module mctb_front (
   input  logic              clock,
   input  logic              reset,
   input  mctb_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_stall,
   output mctb_pkg::job_type job_data,
   output logic              job_valid,
   input  logic              job_pop
);
   import mctb_pkg::*;

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type    job_in;
   logic       push, pop;

   // decode the command code into its enum
   always_comb begin
      job_in.cmd = cmd_type'(req_data.command);
      job_in.idx = req_data.slot_index;
      job_in.ivl = req_data.interval_ms;
      job_in.rep = req_data.repeat_mode;
      job_in.now = req_data.now_us;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job_data  = q_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[sv/mctb_back.sv]
`include "multi_channel_timer_bank_unit_macros.svh"

module mctb_back #(
   parameter int NUM_SLOTS = mctb_pkg::NumSlotsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  mctb_pkg::job_type job_data,
   input  logic              job_valid,
   output logic              job_pop,
   output mctb_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);
   import mctb_pkg::*;

   localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MUL, S_UPD, S_DIFF, S_DIV, S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   job_type               job_ff, job_in;
   logic [SlotW-1:0]      slot_ff, slot_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic                  found_ff, found_in;
   logic                  any_ff, any_in;
   logic [TimeW-1:0]      best_ff, best_in;
   logic [TimeW-1:0]      base_ff, base_in;
   logic [ProdW-1:0]      prod_ff, prod_in;
   res_type               res_buf_ff [MaxResults];
   logic [ResCntW-1:0]    res_cnt_ff, res_cnt_in;
   logic [ResIdxW-1:0]    emit_idx_ff, emit_idx_in;
   logic [TimeW-1:0]      dvd_ff, dvd_in;
   logic [RemW-1:0]       rem_ff, rem_in;
   logic [DivCntW-1:0]    div_cnt_ff, div_cnt_in;
   logic [RecipW-1:0]     recip_ff, recip_in;
   logic [NtW-1:0]        nt_ff, nt_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // slot stores, read data registered
   logic [TimeW-1:0] dl_mem  [NUM_SLOTS];
   logic [IvlW-1:0]  ivl_mem [NUM_SLOTS];
   logic             per_mem [NUM_SLOTS];
   logic [TimeW-1:0] dl_rd_ff;
   logic [IvlW-1:0]  ivl_rd_ff;
   logic             per_rd_ff;

   logic             dl_we, cfg_we;
   logic [TimeW-1:0] dl_wdata;
   logic             res_we;
   logic [ResIdxW-1:0] res_widx;
   res_type          res_wdata;

   logic [TimeW:0]   sum;
   logic [TimeW-1:0] sat;
   logic             act, new_act, hit, rsp_load, is_last;
   logic [TimeW-1:0] new_dl;
   logic [IvlW-1:0]  mul_op;
   logic [ValW-1:0]   dval;
   logic [ChunkW-1:0] qdig;
   logic [ValW-1:0]   qprod;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign job_pop   = (state_ff == S_IDLE) && job_valid;
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign is_last   = ({1'b0, emit_idx_ff} + 5'd1) == res_cnt_ff;

   always_comb begin
      sum    = {1'b0, base_ff} + {{(TimeW + 1 - ProdW){1'b0}}, prod_ff};
      sat    = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
      act    = active_ff[slot_ff];
      hit    = (ExtW'(job_ff.idx) == ExtW'(slot_ff));
      mul_op = (job_ff.cmd == CMD_CREATE) ? job_ff.ivl : ivl_rd_ff;
      dval   = {rem_ff, dvd_ff[TimeW-1 -: ChunkW]};
      qdig   = recip_ff[RecipShift +: ChunkW];
      qprod  = ValW'(qdig) * ValW'(UsPerMs);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      slot_in      = slot_ff;
      active_in    = active_ff;
      found_in     = found_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      res_cnt_in   = res_cnt_ff;
      emit_idx_in  = emit_idx_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      recip_in     = recip_ff;
      nt_in        = nt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dl_we        = 1'b0;
      cfg_we       = 1'b0;
      dl_wdata     = sat;
      res_we       = 1'b0;
      res_widx     = res_cnt_ff[ResIdxW-1:0];
      res_wdata    = '{slot: 4'd0, status: ST_OK, fired: 1'b0};
      new_act      = act;
      new_dl       = dl_rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in      = job_data;
               slot_in     = '0;
               found_in    = 1'b0;
               any_in      = 1'b0;
               emit_idx_in = '0;
               state_in    = S_READ;
               // single-result commands start from their failure answer
               res_widx    = '0;
               case (job_data.cmd)
                  CMD_CREATE: begin
                     res_we     = 1'b1;
                     res_wdata  = '{slot: 4'd0, status: ST_FULL, fired: 1'b0};
                     res_cnt_in = 5'd1;
                  end
                  CMD_CANCEL, CMD_RESET: begin
                     res_we     = 1'b1;
                     res_wdata  = '{slot: job_data.idx, status: ST_INACTIVE, fired: 1'b0};
                     res_cnt_in = 5'd1;
                  end
                  default: begin
                     res_cnt_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = ProdW'(mul_op) * ProdW'(UsPerMs);
            base_in  = (job_ff.cmd == CMD_RUN) ? dl_rd_ff : job_ff.now;
            state_in = S_UPD;
         end
         S_UPD: begin
            case (job_ff.cmd)
               CMD_CREATE: begin
                  if (!act && !found_ff) begin
                     new_act   = 1'b1;
                     new_dl    = sat;
                     dl_we     = 1'b1;
                     cfg_we    = 1'b1;
                     found_in  = 1'b1;
                     res_we    = 1'b1;
                     res_widx  = '0;
                     res_wdata = '{slot: 4'(slot_ff), status: ST_OK, fired: 1'b0};
                  end
               end
               CMD_CANCEL: begin
                  if (hit && act) begin
                     new_act   = 1'b0;
                     res_we    = 1'b1;
                     res_widx  = '0;
                     res_wdata = '{slot: job_ff.idx, status: ST_OK, fired: 1'b0};
                  end
               end
               CMD_RESET: begin
                  if (hit && act) begin
                     new_dl    = sat;
                     dl_we     = 1'b1;
                     res_we    = 1'b1;
                     res_widx  = '0;
                     res_wdata = '{slot: job_ff.idx, status: ST_OK, fired: 1'b0};
                  end
               end
               default: begin
                  if (act && (dl_rd_ff <= job_ff.now) &&
                      (res_cnt_ff < ResCntW'(MaxResults))) begin
                     if (per_rd_ff) begin
                        new_dl = sat;
                        dl_we  = 1'b1;
                     end else begin
                        new_act = 1'b0;
                     end
                     res_we     = 1'b1;
                     res_wdata  = '{slot: 4'(slot_ff), status: ST_OK, fired: 1'b1};
                     res_cnt_in = res_cnt_ff + 5'd1;
                  end
               end
            endcase
            active_in[slot_ff] = new_act;
            // running minimum over the updated deadlines
            if (new_act && (!any_ff || (new_dl < best_ff))) begin
               best_in = new_dl;
               any_in  = 1'b1;
            end
            if (slot_ff == SlotW'(NUM_SLOTS - 1)) begin
               state_in = S_DIFF;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DIFF: begin
            if (res_cnt_ff == '0) begin
               res_we     = 1'b1;
               res_widx   = '0;
               res_cnt_in = 5'd1;
            end
            rem_in     = '0;
            div_cnt_in = '0;
            dvd_in     = best_ff - job_ff.now;
            if (!any_ff) begin
               nt_in    = '1;
               state_in = S_EMIT;
            end else if (best_ff <= job_ff.now) begin
               nt_in    = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // division by 1000, one 16-bit chunk at a time: a reciprocal multiply step,
            // then a quotient digit and remainder step
            if (!div_cnt_ff[0]) begin
               recip_in = RecipW'(dval) * RecipW'(RecipM);
            end else begin
               rem_in = RemW'(dval - qprod);
               dvd_in = {dvd_ff[TimeW-ChunkW-1:0], qdig};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DivCntW'(DivSteps - 1)) begin
               nt_in    = dvd_in[NtW-1:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_in.slot_out        = res_buf_ff[emit_idx_ff].slot;
               rsp_in.status          = res_buf_ff[emit_idx_ff].status;
               rsp_in.fired           = res_buf_ff[emit_idx_ff].fired;
               rsp_in.next_timeout_ms = nt_ff;
               rsp_in.last_result     = is_last;
               rsp_valid_in           = 1'b1;
               emit_idx_in            = emit_idx_ff + 1'b1;
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[slot_ff] <= dl_wdata;
      end
      if (cfg_we) begin
         ivl_mem[slot_ff] <= job_ff.ivl;
         per_mem[slot_ff] <= job_ff.rep;
      end
      dl_rd_ff  <= dl_mem[slot_ff];
      ivl_rd_ff <= ivl_mem[slot_ff];
      per_rd_ff <= per_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         slot_ff      <= slot_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         best_ff      <= best_in;
         base_ff      <= base_in;
         prod_ff      <= prod_in;
         res_cnt_ff   <= res_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         dvd_ff       <= dvd_in;
         rem_ff       <= rem_in;
         div_cnt_ff   <= div_cnt_in;
         recip_ff     <= recip_in;
         nt_ff        <= nt_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (res_we) begin
            res_buf_ff[res_widx] <= res_wdata;
         end
      end
   end

   `MCTB_ASSERT_ALWAYS(a_res_cnt_max, clock, reset, res_cnt_ff <= ResCntW'(MaxResults))
   `MCTB_ASSERT_IMPLY(a_emit_nonempty, clock, reset, state_ff == S_EMIT, res_cnt_ff != '0)
   `MCTB_ASSERT_NEXT(a_last_to_idle, clock, reset, (state_ff == S_EMIT) && rsp_load && is_last, (state_ff == S_IDLE) && rsp_valid_ff && rsp_ff.last_result)

endmodule

[sv/multi_channel_timer_bank_unit.sv]
// timer bank: a set of one-shot or periodic timer slots driven by host commands
// req channel: one item per command (create, cancel, reset, run expiry check),
//   each carrying the current time in microseconds
// rsp channel: one result per create/cancel/reset, one per fired slot on run
//   (up to 16, ascending slot order) or a single empty result when none fired;
//   last_result marks the final result of an item, and every result carries
//   the milliseconds to the earliest remaining deadline
// operation: a command makes one pass over all slots (read, multiply, update
//   per slot), then a division by 1000 in 16-bit chunks when a deadline lies
//   ahead, then one result per cycle while rsp is not stalled
// throughput: one command at a time in the back end; a two-entry queue in the
//   front lets the host post the next command while the current one runs
// reset: all slots become free, queue and output register empty
// stall on rsp holds the current result in the output register and pauses the
//   back end; the front keeps taking items until its queue fills
module multi_channel_timer_bank_unit #(
   parameter int NUM_SLOTS = mctb_pkg::NumSlotsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  mctb_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_stall,
   output mctb_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);
   import mctb_pkg::*;

   // classified commands between front and back
   job_type job_data;
   logic    job_valid;
   logic    job_pop;

   // front: accept, decode and queue
   mctb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .job_data  (job_data),
      .job_valid (job_valid),
      .job_pop   (job_pop)
   );

   // back: slot pass, next-timeout division and result output
   mctb_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

[bench/timer_bank_checker.sv]
module timer_bank_checker (
   input  logic              clock,
   input  logic              reset,
   input  mctb_pkg::req_type req_data,
   input  logic              req_valid,
   input  logic              req_stall,
   input  mctb_pkg::rsp_type rsp_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   output int                fail_count,
   output int                pending_count
);
   import mctb_pkg::*;

   localparam logic [47:0] TOP_US = 48'hFFFF_FFFF_FFFF;

   logic [47:0] deadline_q [16];
   logic [31:0] interval_q [16];
   logic        periodic_q [16];
   logic        active_q   [16];
   rsp_type     expected_rsp [$];

   function automatic logic [47:0] sat_add(logic [47:0] base, logic [31:0] ms);
      logic [63:0] sum;
      sum = {16'd0, base} + {32'd0, ms} * 64'd1000;
      return (sum > {16'd0, TOP_US}) ? TOP_US : sum[47:0];
   endfunction

   task automatic report(string what, rsp_type got, rsp_type want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   task automatic predict_item(req_type r);
      rsp_type     out [$];
      rsp_type     one;
      logic        any;
      logic [47:0] best;
      logic [39:0] nt;
      int          free_slot;
      free_slot = -1;
      one = '0;
      case (cmd_type'(r.command))
         CMD_CREATE: begin
            for (int i = 15; i >= 0; i--) if (!active_q[i]) free_slot = i;
            if (free_slot >= 0) begin
               active_q[free_slot] = 1'b1;
               interval_q[free_slot] = r.interval_ms;
               periodic_q[free_slot] = r.repeat_mode;
               deadline_q[free_slot] = sat_add(r.now_us, r.interval_ms);
               one.slot_out = free_slot[3:0];
               one.status = ST_OK;
            end else begin
               one.status = ST_FULL;
            end
            out.push_back(one);
         end
         CMD_CANCEL, CMD_RESET: begin
            one.slot_out = r.slot_index;
            if (active_q[r.slot_index]) begin
               one.status = ST_OK;
               if (r.command == CMD_CANCEL) active_q[r.slot_index] = 1'b0;
               else deadline_q[r.slot_index] =
                  sat_add(r.now_us, interval_q[r.slot_index]);
            end else begin
               one.status = ST_INACTIVE;
            end
            out.push_back(one);
         end
         default: begin
            for (int i = 0; i < 16; i++) begin
               if (active_q[i] && deadline_q[i] <= r.now_us) begin
                  if (periodic_q[i]) deadline_q[i] = sat_add(deadline_q[i], interval_q[i]);
                  else active_q[i] = 1'b0;
                  one = '0;
                  one.slot_out = i[3:0];
                  one.status = ST_OK;
                  one.fired = 1'b1;
                  out.push_back(one);
               end
            end
            if (out.size() == 0) begin
               one = '0;
               out.push_back(one);
            end
         end
      endcase
      any = 1'b0;
      best = '0;
      for (int i = 0; i < 16; i++)
         if (active_q[i] && (!any || deadline_q[i] < best)) begin
            best = deadline_q[i];
            any = 1'b1;
         end
      if (!any) nt = '1;
      else if (best <= r.now_us) nt = '0;
      else nt = 40'((best - r.now_us) / 48'd1000);
      foreach (out[k]) begin
         out[k].next_timeout_ms = nt;
         out[k].last_result = (k == out.size() - 1);
         expected_rsp.push_back(out[k]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         pending_count = 0;
         expected_rsp.delete();
         for (int i = 0; i < 16; i++) active_q[i] = 1'b0;
      end else begin
         // results first: the item accepted this edge cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected item", rsp_data, '0);
            end else begin
               rsp_type want;
               want = expected_rsp.pop_front();
               if (rsp_data.slot_out !== want.slot_out) report("slot_out", rsp_data, want);
               if (rsp_data.status !== want.status) report("status", rsp_data, want);
               if (rsp_data.fired !== want.fired) report("fired", rsp_data, want);
               if (rsp_data.next_timeout_ms !== want.next_timeout_ms)
                  report("next_timeout_ms", rsp_data, want);
               if (rsp_data.last_result !== want.last_result)
                  report("last_result", rsp_data, want);
            end
         end
         if (req_valid && !req_stall) predict_item(req_data);
         pending_count = expected_rsp.size();
      end
   end
endmodule

[bench/testbench.sv]
module testbench;
   import mctb_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   req_type req_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rsp_type rsp_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   int      fail_count;
   int      pending_count;
   logic    hold_off = 1'b0;   // long receiver pause
   logic [47:0] now_clock = 48'd1000;  // running time seen by the bank

   always #2 clock = ~clock;

   multi_channel_timer_bank_unit u_top (
      .clock(clock), .reset(reset),
      .req_data(req_data), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
   );

   timer_bank_checker u_checker (
      .clock(clock), .reset(reset),
      .req_data(req_data), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // gap length: mostly short, sometimes long
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // offer one item and wait for acceptance
   task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [31:0] ivl,
                            logic rep, logic [47:0] now);
      req_type item;
      item.command = cmd;
      item.slot_index = idx;
      item.interval_ms = ivl;
      item.repeat_mode = rep;
      item.now_us = now;
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_gap();
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // receiver: random stall, plus one long hold-off
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_stall <= hold_off;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [31:0] ivl;
      logic [1:0]  cmd;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty run, inactive cancel/reset, fill the bank, full create
      send_item(CMD_RUN, 4'd0, 32'd0, 1'b0, 48'd0);
      send_item(CMD_CANCEL, 4'd15, 32'd0, 1'b0, 48'd5);
      send_item(CMD_RESET, 4'd3, 32'd0, 1'b0, 48'd5);
      for (int i = 0; i < 16; i++)
         send_item(CMD_CREATE, 4'd0,
                   (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : 32'(i * 3),
                   i[0], (i == 0) ? 48'hFFFF_FFFF_FFF0 : 48'd1000);
      send_item(CMD_CREATE, 4'd0, 32'd7, 1'b1, 48'd2000);
      send_item(CMD_RESET, 4'd2, 32'd0, 1'b0, 48'd1500);
      send_item(CMD_RUN, 4'hA, 32'd0, 1'b0, 48'd100000);       // many fire at once
      send_item(CMD_RUN, 4'd0, 32'd0, 1'b0, 48'hFFFF_FFFF_FFFF);  // everything left
      send_item(CMD_CANCEL, 4'd1, 32'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      // random: mostly create/run with a rising clock, some noise
      for (int n = 0; n < 146; n++) begin
         if (n == 60) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         if ($urandom_range(0, 19) == 0) now_clock = 48'({$urandom, $urandom});
         else now_clock = now_clock + $urandom_range(0, 20000);
         case ($urandom_range(0, 9))
            0, 1, 2: cmd = CMD_CREATE;
            3:       cmd = CMD_CANCEL;
            4:       cmd = CMD_RESET;
            default: cmd = CMD_RUN;
         endcase
         case ($urandom_range(0, 9))
            0:       ivl = $urandom;
            1:       ivl = 32'd0;
            default: ivl = $urandom_range(0, 40);
         endcase
         send_item(cmd, 4'($urandom), ivl, 1'($urandom), now_clock);
         sender_gap();
      end
      req_valid <= 1'b0;
      while (pending_count != 0 || hold_off) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule

[files.f]
+incdir+sv
sv/mctb_pkg.sv
sv/mctb_front.sv
sv/mctb_back.sv
sv/multi_channel_timer_bank_unit.sv
bench/timer_bank_checker.sv
bench/testbench.sv
